### sv/assert_macros.svh
// assertion macros shared by the sort key encoder rtl
// depends on nothing; included by the modules that check their own logic
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising clock edge outside reset
`define SKFE_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// condition that must never hold outside reset
`define SKFE_NEVER(label, clk, rst_n, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

### sv/skfe_pkg.sv
// types, mode codes and float constants of the sort key encoder
// depends on nothing; used by every module of the encoder
`default_nettype none

package skfe_pkg;

  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned WORD_W    = 64;
  localparam int unsigned MAX_BYTES = 9;
  localparam int unsigned BUF_W     = MAX_BYTES * BYTE_W;
  localparam int unsigned CNT_W     = 4;

  // field modes
  localparam logic [3:0] MODE_INT64     = 4'd0;
  localparam logic [3:0] MODE_INT32     = 4'd1;
  localparam logic [3:0] MODE_INT16     = 4'd2;
  localparam logic [3:0] MODE_INT8      = 4'd3;
  localparam logic [3:0] MODE_BOOL      = 4'd4;
  localparam logic [3:0] MODE_DOUBLE    = 4'd5;
  localparam logic [3:0] MODE_REAL      = 4'd6;
  localparam logic [3:0] MODE_STR_BYTE  = 4'd7;
  localparam logic [3:0] MODE_EMPTY_STR = 4'd8;

  localparam logic [63:0] DBL_EXP_MASK = 64'h7FF0_0000_0000_0000;
  localparam logic [63:0] DBL_MAN_MASK = 64'h000F_FFFF_FFFF_FFFF;
  localparam logic [63:0] DBL_QNAN     = 64'h7FF8_0000_0000_0000;
  localparam logic [63:0] SIGN64       = 64'h8000_0000_0000_0000;
  localparam logic [31:0] FLT_EXP_MASK = 32'h7F80_0000;
  localparam logic [31:0] FLT_MAN_MASK = 32'h007F_FFFF;
  localparam logic [31:0] FLT_QNAN     = 32'h7FC0_0000;
  localparam logic [31:0] SIGN32       = 32'h8000_0000;
  localparam logic [15:0] SIGN16       = 16'h8000;
  localparam logic [7:0]  SIGN8        = 8'h80;
  localparam logic [7:0]  BOOL_TRUE    = 8'h02;
  localparam logic [7:0]  BOOL_FALSE   = 8'h01;
  localparam logic [7:0]  ESC_BYTE     = 8'h01;

  typedef struct packed {
    logic [3:0]  mode;
    logic        is_null;
    logic [63:0] value;
    logic        null_last;
    logic        descending;
    logic        first_byte;
    logic        last_byte;
  } skfe_in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       end_of_run;
  } skfe_out_t;

  // stage 1 result: data bytes left-justified, presence byte apart
  typedef struct packed {
    logic              pres;
    logic [7:0]        pres_byte;
    logic              inv;
    logic [63:0]       dword;
    logic [CNT_W-1:0]  dcnt;
  } skfe_xf_t;

  // stage 2 result: whole run of bytes, first byte in the top lane
  typedef struct packed {
    logic [BUF_W-1:0] bytes;
    logic [CNT_W-1:0] total;
  } skfe_pk_t;

endpackage

`default_nettype wire

### sv/skfe_xform.sv
// stage 1 of the sort key encoder: value transform per mode
// depends on skfe_pkg and assert_macros.svh
`default_nettype none
`include "assert_macros.svh"

module skfe_xform (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire skfe_pkg::skfe_in_t in_data,
  output logic                   xf_valid,
  input  wire logic              xf_ready,
  output skfe_pkg::skfe_xf_t     xf_data
);

  logic               valid_r;
  logic               valid_nxt;
  skfe_pkg::skfe_xf_t xf_r;
  skfe_pkg::skfe_xf_t xf_nxt;
  logic [63:0]        dbl_w;
  logic [63:0]        dbl_enc;
  logic [31:0]        flt_w;
  logic [31:0]        flt_enc;
  logic [7:0]         sbyte;
  logic               mode_ok;

  assign in_ready = !valid_r || xf_ready;
  assign mode_ok  = in_data.mode <= skfe_pkg::MODE_EMPTY_STR;

  // canonical nan, then sign handling
  always_comb begin
    dbl_w = in_data.value;
    if ((dbl_w & skfe_pkg::DBL_EXP_MASK) == skfe_pkg::DBL_EXP_MASK &&
        (dbl_w & skfe_pkg::DBL_MAN_MASK) != '0) begin
      dbl_w = skfe_pkg::DBL_QNAN;
    end
    dbl_enc = dbl_w[63] ? ~dbl_w : (dbl_w ^ skfe_pkg::SIGN64);
  end

  always_comb begin
    flt_w = in_data.value[31:0];
    if ((flt_w & skfe_pkg::FLT_EXP_MASK) == skfe_pkg::FLT_EXP_MASK &&
        (flt_w & skfe_pkg::FLT_MAN_MASK) != '0) begin
      flt_w = skfe_pkg::FLT_QNAN;
    end
    flt_enc = flt_w[31] ? ~flt_w : (flt_w ^ skfe_pkg::SIGN32);
  end

  assign sbyte = in_data.value[7:0];

  always_comb begin
    xf_nxt           = '0;
    xf_nxt.inv       = in_data.descending;
    xf_nxt.pres      = 1'b1;
    xf_nxt.pres_byte = {7'd0, in_data.is_null ? in_data.null_last : !in_data.null_last};
    if (!in_data.is_null) begin
      unique case (in_data.mode)
        skfe_pkg::MODE_INT64: begin
          xf_nxt.dword = in_data.value ^ skfe_pkg::SIGN64;
          xf_nxt.dcnt  = 4'd8;
        end
        skfe_pkg::MODE_INT32: begin
          xf_nxt.dword = {in_data.value[31:0] ^ skfe_pkg::SIGN32, 32'd0};
          xf_nxt.dcnt  = 4'd4;
        end
        skfe_pkg::MODE_INT16: begin
          xf_nxt.dword = {in_data.value[15:0] ^ skfe_pkg::SIGN16, 48'd0};
          xf_nxt.dcnt  = 4'd2;
        end
        skfe_pkg::MODE_INT8: begin
          xf_nxt.dword = {in_data.value[7:0] ^ skfe_pkg::SIGN8, 56'd0};
          xf_nxt.dcnt  = 4'd1;
        end
        skfe_pkg::MODE_BOOL: begin
          xf_nxt.dword = {in_data.value[0] ? skfe_pkg::BOOL_TRUE : skfe_pkg::BOOL_FALSE,
                          56'd0};
          xf_nxt.dcnt  = 4'd1;
        end
        skfe_pkg::MODE_DOUBLE: begin
          xf_nxt.dword = dbl_enc;
          xf_nxt.dcnt  = 4'd8;
        end
        skfe_pkg::MODE_REAL: begin
          xf_nxt.dword = {flt_enc, 32'd0};
          xf_nxt.dcnt  = 4'd4;
        end
        skfe_pkg::MODE_STR_BYTE: begin
          // terminator is the zero fill after the byte
          xf_nxt.pres = in_data.first_byte;
          if (sbyte[7:1] == 7'd0) begin
            xf_nxt.dword = {skfe_pkg::ESC_BYTE, sbyte, 48'd0};
            xf_nxt.dcnt  = 4'd2 + {3'd0, in_data.last_byte};
          end else begin
            xf_nxt.dword = {sbyte, 56'd0};
            xf_nxt.dcnt  = 4'd1 + {3'd0, in_data.last_byte};
          end
        end
        skfe_pkg::MODE_EMPTY_STR: begin
          xf_nxt.dword = '0;
          xf_nxt.dcnt  = 4'd1;
        end
        default: begin
          xf_nxt.dcnt = '0;
        end
      endcase
    end
  end

  // unused modes are dropped here
  assign valid_nxt = in_valid && mode_ok;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= valid_nxt;
    end
    if (in_valid && in_ready) begin
      xf_r <= xf_nxt;
    end
  end

  assign xf_valid = valid_r;
  assign xf_data  = xf_r;

  `SKFE_ASSERT(a_xf_nonempty, clk, rst_n, valid_r |-> (xf_r.pres || xf_r.dcnt != '0), "stage 1 word with no bytes")
  `SKFE_ASSERT(a_xf_hold, clk, rst_n, (valid_r && !xf_ready) |=> (valid_r && $stable(xf_r)), "stage 1 lost a stalled word")

endmodule

`default_nettype wire

### sv/skfe_pack.sv
// stage 2 of the sort key encoder: descending inversion and presence byte merge
// depends on skfe_pkg and assert_macros.svh
`default_nettype none
`include "assert_macros.svh"

module skfe_pack (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               xf_valid,
  output logic                    xf_ready,
  input  wire skfe_pkg::skfe_xf_t xf_data,
  output logic                    pk_valid,
  input  wire logic               pk_ready,
  output skfe_pkg::skfe_pk_t      pk_data
);

  logic               valid_r;
  skfe_pkg::skfe_pk_t pk_r;
  skfe_pkg::skfe_pk_t pk_nxt;
  logic [63:0]        data_w;

  assign xf_ready = !valid_r || pk_ready;
  assign data_w   = xf_data.dword ^ {skfe_pkg::WORD_W{xf_data.inv}};

  always_comb begin
    pk_nxt.total = xf_data.dcnt + {3'd0, xf_data.pres};
    if (xf_data.pres) begin
      pk_nxt.bytes = {xf_data.pres_byte, data_w};
    end else begin
      pk_nxt.bytes = {data_w, 8'd0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (xf_ready) begin
      valid_r <= xf_valid;
    end
    if (xf_valid && xf_ready) begin
      pk_r <= pk_nxt;
    end
  end

  assign pk_valid = valid_r;
  assign pk_data  = pk_r;

  `SKFE_ASSERT(a_pk_total, clk, rst_n, valid_r |-> (pk_r.total != '0 && pk_r.total <= 4'd9), "run length out of range")

endmodule

`default_nettype wire

### sv/skfe_serial.sv
// stage 3 of the sort key encoder: byte serializer driving the output register
// depends on skfe_pkg and assert_macros.svh
`default_nettype none
`include "assert_macros.svh"

module skfe_serial (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               pk_valid,
  output logic                    pk_ready,
  input  wire skfe_pkg::skfe_pk_t pk_data,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output skfe_pkg::skfe_out_t     out_data
);

  logic [skfe_pkg::BUF_W-1:0] buf_r;
  logic [skfe_pkg::BUF_W-1:0] buf_nxt;
  logic [skfe_pkg::CNT_W-1:0] left_r;
  logic [skfe_pkg::CNT_W-1:0] left_nxt;
  logic                       load;
  logic                       shift;

  // a new run loads as the last byte of the current one leaves
  assign pk_ready = (left_r == '0) || (left_r == 4'd1 && out_ready);
  assign load     = pk_valid && pk_ready;
  assign shift    = (left_r != '0) && out_ready;

  always_comb begin
    buf_nxt  = buf_r;
    left_nxt = left_r;
    if (load) begin
      buf_nxt  = pk_data.bytes;
      left_nxt = pk_data.total;
    end else if (shift) begin
      buf_nxt  = {buf_r[skfe_pkg::BUF_W-skfe_pkg::BYTE_W-1:0], 8'd0};
      left_nxt = left_r - 4'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      left_r <= '0;
    end else begin
      left_r <= left_nxt;
    end
    buf_r <= buf_nxt;
  end

  assign out_valid           = left_r != '0;
  assign out_data.out_byte   = buf_r[skfe_pkg::BUF_W-1 -: skfe_pkg::BYTE_W];
  assign out_data.end_of_run = left_r == 4'd1;

  `SKFE_ASSERT(a_run_continues, clk, rst_n, (out_valid && out_ready && !out_data.end_of_run) |=> out_valid, "run cut short")
  `SKFE_NEVER(a_no_overwrite, clk, rst_n, load && left_r > 4'd1, "run overwritten")

endmodule

`default_nettype wire

### sv/sort_key_field_encoder.sv
// top level of the sort key field encoder
// depends on skfe_pkg, skfe_xform, skfe_pack and skfe_serial
`default_nettype none

// Encodes one key field (or one byte of a string field) per input word into
// key bytes whose unsigned byte order is the field's sort order, nulls first
// or last as asked, descending fields inverted after the presence byte.
// Words flow through two pipeline registers (mode transform, then inversion
// and presence merge) into a serializer that sends one byte per cycle while
// out_ready is high; the first byte of a word reaches the output once both
// registers and then the serializer buffer have taken it. A word's run has 9
// bytes for int64 and double, 5 for int32 and real, 3 for int16, 2 for int8,
// bool, null-free empty string, 1 for a null, 1 to 4 for a string byte. The
// serializer's byte rate sets the sustained rate; the two upstream registers
// each hold one more word while a run drains, and the next run starts in the
// cycle after the last byte of the current one is taken. A word with an
// unused mode (9 to 15) is taken and yields no bytes. end_of_run marks each
// run's last byte. No configuration and no state beyond the pipeline.
module sort_key_field_encoder (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire skfe_pkg::skfe_in_t  in_data,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output skfe_pkg::skfe_out_t      out_data
);

  // stage 1 to stage 2
  logic               xf_valid;
  logic               xf_ready;
  skfe_pkg::skfe_xf_t xf_data;

  // stage 2 to serializer
  logic               pk_valid;
  logic               pk_ready;
  skfe_pkg::skfe_pk_t pk_data;

  // mode decode, nan canonicalization, sign flips, string escapes
  skfe_xform u_xform (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .xf_valid (xf_valid),
    .xf_ready (xf_ready),
    .xf_data  (xf_data)
  );

  // descending inversion of data bytes, presence byte in front
  skfe_pack u_pack (
    .clk      (clk),
    .rst_n    (rst_n),
    .xf_valid (xf_valid),
    .xf_ready (xf_ready),
    .xf_data  (xf_data),
    .pk_valid (pk_valid),
    .pk_ready (pk_ready),
    .pk_data  (pk_data)
  );

  // one byte per cycle out of the run buffer while out_ready is high
  skfe_serial u_serial (
    .clk       (clk),
    .rst_n     (rst_n),
    .pk_valid  (pk_valid),
    .pk_ready  (pk_ready),
    .pk_data   (pk_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

### tb/skfe_tb_pkg.sv
// expected key byte store and field encoder predictor for the testbench
// depends on skfe_pkg for the word types, mode codes and float constants
`timescale 1ns / 100ps

package skfe_tb_pkg;
  import skfe_pkg::*;

  localparam logic [7:0] KEY_TERMINATOR = 8'h00;
  localparam int unsigned MAX_REPORTS = 100;

  class key_byte_board;
    skfe_out_t expected_bytes[$];
    int unsigned fields_noted;
    int unsigned words_ignored;
    int unsigned bytes_checked;
    int unsigned mismatches;

    // works out the key bytes one accepted word must produce
    function void note_field(skfe_in_t f);
      logic [7:0] data[$];
      logic [7:0] run[$];
      logic [63:0] w;
      logic [31:0] s;
      skfe_out_t b;
      int n;
      if (f.mode > MODE_EMPTY_STR) begin
        words_ignored++;
        return;
      end
      fields_noted++;
      n = 0;
      w = '0;
      if (f.is_null) begin
        run.push_back({7'h0, f.null_last});
      end else begin
        if (f.mode != MODE_STR_BYTE || f.first_byte) run.push_back({7'h0, ~f.null_last});
        case (f.mode)
          MODE_INT64: begin
            w = f.value ^ SIGN64;
            n = 8;
          end
          MODE_INT32: begin
            w = {32'h0, f.value[31:0] ^ SIGN32};
            n = 4;
          end
          MODE_INT16: begin
            w = {48'h0, f.value[15:0] ^ SIGN16};
            n = 2;
          end
          MODE_INT8: begin
            w = {56'h0, f.value[7:0] ^ SIGN8};
            n = 1;
          end
          MODE_BOOL: begin
            w = {56'h0, f.value[0] ? BOOL_TRUE : BOOL_FALSE};
            n = 1;
          end
          MODE_DOUBLE: begin
            w = f.value;
            if ((w & DBL_EXP_MASK) == DBL_EXP_MASK && (w & DBL_MAN_MASK) != '0) w = DBL_QNAN;
            w = w[63] ? ~w : w ^ SIGN64;
            n = 8;
          end
          MODE_REAL: begin
            s = f.value[31:0];
            if ((s & FLT_EXP_MASK) == FLT_EXP_MASK && (s & FLT_MAN_MASK) != '0) s = FLT_QNAN;
            s = s[31] ? ~s : s ^ SIGN32;
            w = {32'h0, s};
            n = 4;
          end
          MODE_STR_BYTE: begin
            // bytes 0 and 1 get an escape in front
            if (f.value[7:1] == 7'h0) data.push_back(ESC_BYTE);
            data.push_back(f.value[7:0]);
            if (f.last_byte) data.push_back(KEY_TERMINATOR);
          end
          default: data.push_back(KEY_TERMINATOR);
        endcase
        for (int i = n; i > 0; i--) data.push_back(w[(i-1)*8 +: 8]);
        foreach (data[i]) run.push_back(f.descending ? ~data[i] : data[i]);
      end
      foreach (run[i]) begin
        b.out_byte = run[i];
        b.end_of_run = (i == run.size() - 1);
        expected_bytes.push_back(b);
      end
    endfunction

    function void check_byte(skfe_out_t got);
      skfe_out_t want;
      bytes_checked++;
      if (expected_bytes.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("%0t: key byte %02h end_of_run %0b arrived, expected none",
                   $time, got.out_byte, got.end_of_run);
        return;
      end
      want = expected_bytes.pop_front();
      if (got.out_byte !== want.out_byte) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("%0t: out_byte expected %02h actual %02h",
                   $time, want.out_byte, got.out_byte);
      end
      if (got.end_of_run !== want.end_of_run) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("%0t: end_of_run expected %0b actual %0b (byte %02h)",
                   $time, want.end_of_run, got.end_of_run, want.out_byte);
      end
    endfunction
  endclass

endpackage

### tb/tb_sort_key_field_encoder.sv
// self-checking testbench of the sort key field encoder
// depends on skfe_pkg, skfe_tb_pkg and the sort_key_field_encoder rtl
`timescale 1ns / 100ps

module tb_sort_key_field_encoder;
  import skfe_pkg::*;
  import skfe_tb_pkg::*;

  localparam int unsigned RESET_CYCLES   = 7;
  localparam int unsigned RANDOM_FIELDS  = 110;
  localparam int unsigned HOLD_CYCLES    = 80;  // long receiver hold-off
  localparam int unsigned PRESSURE_WORDS = 12;  // int64 words offered during it
  localparam int unsigned LATENCY_SLACK  = 8;   // pipeline is three deep

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_ready;
  skfe_in_t  in_data;
  logic      out_valid;
  logic      out_ready;
  skfe_out_t out_data;

  key_byte_board board;
  bit          hold_off_request = 1'b0;
  int unsigned burst_left = 0;

  sort_key_field_encoder dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // hard stop in case the block hangs
  initial begin
    #2_000_000;
    $display("sort_key_field_encoder verification failed");
    $finish;
  end

  initial board = new;

  // both handshakes seen in one place: the word taken is noted before any
  // byte of the same edge is checked
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) board.note_field(in_data);
      if (out_valid && out_ready) board.check_byte(out_data);
    end
  end

  // receiver: a fresh 16-bit ready mask, one bit per phase, from always ready to
  // mostly stalled, plus one long hold-off when the stimulus asks for it
  initial begin : receiver
    logic [15:0] mask;
    int unsigned phase;
    int unsigned hold_left;
    out_ready <= 1'b0;
    mask = '1;
    phase = 0;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (hold_off_request) begin
        hold_off_request = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (phase == 0) begin
        case ($urandom_range(0, 3))
          0: mask = '1;
          1: mask = 16'($urandom);
          2: mask = 16'($urandom) | 16'($urandom);
          default: mask = 16'($urandom) & 16'($urandom);
        endcase
      end
      if (hold_left != 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= mask[phase];
      end
      phase = (phase + 1) % 16;
    end
  end

  function automatic skfe_in_t field_word(input logic [3:0] mode, input logic is_null,
                                          input logic [63:0] value, input logic null_last,
                                          input logic descending, input logic first_byte,
                                          input logic last_byte);
    skfe_in_t f;
    f.mode       = mode;
    f.is_null    = is_null;
    f.value      = value;
    f.null_last  = null_last;
    f.descending = descending;
    f.first_byte = first_byte;
    f.last_byte  = last_byte;
    return f;
  endfunction

  // random value leaning toward sign edges, float specials and escaped bytes
  function automatic logic [63:0] pick_value();
    logic [63:0] v;
    v = {$urandom, $urandom};
    case ($urandom_range(0, 9))
      0: v = '0;
      1: v = '1;
      2: v = SIGN64;
      3: v[62:52] = '1;  // double inf or nan
      4: v[30:23] = '1;  // float inf or nan
      5: v[7:1] = '0;    // string byte 0 or 1
      default: ;
    endcase
    return v;
  endfunction

  // hold valid and payload until the word is taken
  task automatic offer_word(input skfe_in_t f);
    in_valid <= 1'b1;
    in_data  <= f;
    do @(posedge clk); while (!in_ready);
  endtask

  // sender bursts of random length, most of them separated by random gaps
  task automatic paced_word(input skfe_in_t f);
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 12);
      if ($urandom_range(0, 3) != 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end
    end
    burst_left--;
    offer_word(f);
  endtask

  // stop sending until every expected key byte is out
  task automatic drain_key_bytes();
    in_valid <= 1'b0;
    @(posedge clk);
    while (board.expected_bytes.size() != 0) @(posedge clk);
    repeat (LATENCY_SLACK) @(posedge clk);
  endtask

  // one well-formed string field, one word per byte, or an empty string
  task automatic send_string(input int unsigned len);
    logic nl;
    logic desc;
    nl = 1'($urandom);
    desc = 1'($urandom);
    if (len == 0) begin
      paced_word(field_word(MODE_EMPTY_STR, 1'b0, pick_value(), nl, desc,
                            1'($urandom), 1'($urandom)));
    end else begin
      for (int unsigned i = 0; i < len; i++)
        paced_word(field_word(MODE_STR_BYTE, 1'b0, pick_value(), nl, desc,
                              i == 0, i == len - 1));
    end
  endtask

  task automatic directed_fields();
    // integer extremes, narrow types with junk in the upper bits
    offer_word(field_word(MODE_INT64, 1'b0, 64'h0, 1'b0, 1'b0, 1'b0, 1'b0));
    offer_word(field_word(MODE_INT64, 1'b0, '1, 1'b1, 1'b1, 1'b1, 1'b1));
    offer_word(field_word(MODE_INT64, 1'b0, 64'h7FFF_FFFF_FFFF_FFFF, 1'b1, 1'b0, 1'b0, 1'b0));
    offer_word(field_word(MODE_INT64, 1'b0, SIGN64, 1'b0, 1'b1, 1'b0, 1'b0));
    offer_word(field_word(MODE_INT32, 1'b0, 64'hFFFF_FFFF_8000_0000, 1'b0, 1'b0, 1'b0, 1'b0));
    offer_word(field_word(MODE_INT16, 1'b0, 64'hAAAA_AAAA_AAAA_7FFF, 1'b0, 1'b1, 1'b0, 1'b0));
    offer_word(field_word(MODE_INT8, 1'b0, 64'hFFFF_FFFF_FFFF_FF00, 1'b1, 1'b0, 1'b0, 1'b0));
    // bool looks at bit 0 only
    offer_word(field_word(MODE_BOOL, 1'b0, 64'hFFFF_FFFF_FFFF_FFFE, 1'b0, 1'b0, 1'b0, 1'b0));
    offer_word(field_word(MODE_BOOL, 1'b0, 64'h1, 1'b0, 1'b1, 1'b0, 1'b0));
    // doubles: signed nan, inf, negative zero, quiet nan with payload
    offer_word(field_word(MODE_DOUBLE, 1'b0, 64'hFFF0_0000_0000_0001, 1'b0, 1'b0, 1'b0, 1'b0));
    offer_word(field_word(MODE_DOUBLE, 1'b0, DBL_EXP_MASK, 1'b0, 1'b0, 1'b0, 1'b0));
    offer_word(field_word(MODE_DOUBLE, 1'b0, SIGN64, 1'b0, 1'b1, 1'b0, 1'b0));
    offer_word(field_word(MODE_DOUBLE, 1'b0, 64'h7FF8_0000_0000_0001, 1'b1, 1'b0, 1'b0, 1'b0));
    // reals: nan with junk above bit 31, minus one, plus zero
    offer_word(field_word(MODE_REAL, 1'b0, 64'hDEAD_BEEF_FF80_0001, 1'b0, 1'b0, 1'b0, 1'b0));
    offer_word(field_word(MODE_REAL, 1'b0, 64'h0000_0000_BF80_0000, 1'b0, 1'b0, 1'b0, 1'b0));
    offer_word(field_word(MODE_REAL, 1'b0, 64'h0, 1'b1, 1'b1, 1'b0, 1'b0));
    // string: escaped 0 and 1, ff closing, single byte field descending
    offer_word(field_word(MODE_STR_BYTE, 1'b0, 64'hFFFF_FFFF_FFFF_FF00, 1'b0, 1'b0, 1'b1, 1'b0));
    offer_word(field_word(MODE_STR_BYTE, 1'b0, 64'h1, 1'b0, 1'b0, 1'b0, 1'b0));
    offer_word(field_word(MODE_STR_BYTE, 1'b0, 64'hFF, 1'b0, 1'b0, 1'b0, 1'b1));
    offer_word(field_word(MODE_STR_BYTE, 1'b0, 64'h2, 1'b1, 1'b1, 1'b1, 1'b1));
    offer_word(field_word(MODE_EMPTY_STR, 1'b0, 64'h0, 1'b0, 1'b0, 1'b0, 1'b0));
    offer_word(field_word(MODE_EMPTY_STR, 1'b0, '1, 1'b1, 1'b1, 1'b1, 1'b1));
    // nulls ignore first and last flags and descending
    offer_word(field_word(MODE_INT64, 1'b1, '1, 1'b0, 1'b1, 1'b0, 1'b0));
    offer_word(field_word(MODE_STR_BYTE, 1'b1, 64'h5, 1'b1, 1'b1, 1'b0, 1'b1));
    offer_word(field_word(MODE_EMPTY_STR, 1'b1, 64'h0, 1'b1, 1'b0, 1'b1, 1'b1));
    // unused modes are taken and dropped
    offer_word(field_word(4'(MODE_EMPTY_STR + 1), 1'b0, '1, 1'b1, 1'b1, 1'b1, 1'b1));
    offer_word(field_word(4'hF, 1'b1, 64'h0, 1'b0, 1'b0, 1'b0, 1'b0));
  endtask

  // receiver holds off while int64 words keep coming, so the pipeline
  // fills and in_ready drops
  task automatic pressure_burst();
    hold_off_request = 1'b1;
    repeat (PRESSURE_WORDS)
      offer_word(field_word(MODE_INT64, 1'b0, pick_value(), 1'($urandom), 1'($urandom),
                            1'($urandom), 1'($urandom)));
    drain_key_bytes();
  endtask

  initial begin : stimulus
    int unsigned random_fields;
    int unsigned pick;
    int unsigned len;
    bit pressure_done;
    in_valid <= 1'b0;
    in_data  <= '0;
    rst_n    <= 1'b0;
    random_fields = 0;
    pressure_done = 1'b0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    directed_fields();
    drain_key_bytes();

    while (random_fields < RANDOM_FIELDS) begin
      if (!pressure_done && random_fields >= RANDOM_FIELDS / 2) begin
        pressure_burst();
        pressure_done = 1'b1;
      end
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
        // fixed-width field, string flags as noise
        paced_word(field_word(4'($urandom_range(MODE_INT64, MODE_REAL)), 1'b0, pick_value(),
                              1'($urandom), 1'($urandom), 1'($urandom), 1'($urandom)));
        random_fields++;
      end else if (pick < 75) begin
        len = $urandom_range(0, 6);
        send_string(len);
        random_fields += (len == 0) ? 1 : len;
      end else if (pick < 85) begin
        paced_word(field_word(4'($urandom_range(MODE_INT64, MODE_EMPTY_STR)), 1'b1,
                              pick_value(), 1'($urandom), 1'($urandom),
                              1'($urandom), 1'($urandom)));
        random_fields++;
      end else if (pick < 95) begin
        // string byte out of sequence
        paced_word(field_word(MODE_STR_BYTE, ($urandom_range(0, 7) == 0), pick_value(),
                              1'($urandom), 1'($urandom), 1'($urandom), 1'($urandom)));
        random_fields++;
      end else begin
        paced_word(field_word(4'($urandom_range(MODE_EMPTY_STR + 1, 15)), 1'($urandom),
                              pick_value(), 1'($urandom), 1'($urandom),
                              1'($urandom), 1'($urandom)));
      end
    end

    drain_key_bytes();
    $display("run covered %0d encoded fields and %0d dropped words, %0d key bytes checked",
             board.fields_noted, board.words_ignored, board.bytes_checked);
    $display("including all modes, nulls, escapes, descending order and a long output stall");
    if (board.mismatches == 0 && board.expected_bytes.size() == 0) begin
      $display("sort_key_field_encoder verification clean");
    end else begin
      $display("sort_key_field_encoder verification failed");
    end
    $finish;
  end

endmodule
